[src/barc_pkg.sv]
// Shared types, codes and constants of the bump allocator with release count.
package barc_pkg;

   // Arena geometry and widths.
   localparam int BUFFER_BYTES = 4096;
   localparam int PREFIX_BYTES = 8;
   localparam int OFF_W        = 13;
   localparam int SLOT_W       = $clog2(BUFFER_BYTES);
   localparam int ADDR_W       = 32;
   localparam int CSR_IDX_W    = 2;
   localparam int OFFSET_MAX   = 8191;
   localparam int LINE_LOG2_MAX = 12;

   // Command codes; codes above query behave as query.
   typedef enum logic [2:0] {
      CMD_ALLOC  = 3'd0,
      CMD_FREE   = 3'd1,
      CMD_SEAL   = 3'd2,
      CMD_REUSE  = 3'd3,
      CMD_QUERY  = 3'd4
   } command_type;

   // Status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_NO_SPACE    = 2'd1;
   localparam logic [1:0] ST_OUT_OF_RANGE = 2'd2;
   localparam logic [1:0] ST_NOT_DRAINED = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_ENABLE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_LOG2    = 2'd3;

   // Configuration register set.
   typedef struct packed {
      logic [ADDR_W-1:0] base_address;
      logic [OFF_W-1:0]  buffer_size;
      logic              align_enable;
      logic [3:0]        line_log2;
   } cfg_type;

   // One command word as held in the input register.
   typedef struct packed {
      logic [2:0]        command;
      logic [OFF_W-1:0]  request_bytes;
      logic [ADDR_W-1:0] release_address;
   } item_type;

   // Write side of the length store.
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [OFF_W-1:0]  data;
   } store_wr_type;

   // One result word.
   typedef struct packed {
      logic              valid;
      logic [1:0]        status;
      logic [ADDR_W-1:0] granted_address;
      logic [OFF_W-1:0]  free_bytes;
      logic [OFF_W-1:0]  released_bytes;
      logic              drained;
   } rsp_type;

endpackage

[src/barc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module barc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port; a read of the address being
   // written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/barc_core.sv]
// Execute stage: arena pointers, command decode and the result register.
module barc_core (
   input  logic                      clock,
   input  logic                      reset,
   input  barc_pkg::cfg_type         cfg,
   input  logic                      item_valid,
   input  barc_pkg::item_type        item,
   input  logic [barc_pkg::OFF_W-1:0] stored_len,
   output barc_pkg::store_wr_type    store_wr,
   output barc_pkg::rsp_type         rsp
);

   localparam int OFF_W  = barc_pkg::OFF_W;
   localparam int ADDR_W = barc_pkg::ADDR_W;

   logic [OFF_W-1:0] alloc_offset_ff, alloc_offset_in;
   logic [OFF_W-1:0] release_offset_ff, release_offset_in;
   logic [OFF_W-1:0] seal_mark_ff, seal_mark_in;
   barc_pkg::rsp_type rsp_ff, rsp_in;

   logic [OFF_W-1:0]  arena_end;
   logic              sealed;
   logic              drained_now;
   logic [3:0]        line_lg;
   logic [OFF_W:0]    line_mask;
   logic [OFF_W:0]    total_raw;
   logic [OFF_W:0]    total;
   logic [OFF_W:0]    room;
   logic              fits;
   logic [ADDR_W:0]   range_lo;
   logic [ADDR_W:0]   range_hi;
   logic              in_range;
   logic [OFF_W+1:0]  release_sum;
   logic [OFF_W-1:0]  release_sat;
   logic [1:0]        status;
   logic [ADDR_W-1:0] granted;
   logic              drained_next;

   // Arena end, sealed test and alignment of the allocation size.
   always_comb begin
      arena_end = (cfg.buffer_size < OFF_W'(barc_pkg::BUFFER_BYTES)) ?
                  cfg.buffer_size : OFF_W'(barc_pkg::BUFFER_BYTES);
      sealed      = alloc_offset_ff > arena_end;
      drained_now = sealed && (release_offset_ff >= seal_mark_ff);
      line_lg     = (cfg.line_log2 > 4'(barc_pkg::LINE_LOG2_MAX)) ?
                    4'(barc_pkg::LINE_LOG2_MAX) : cfg.line_log2;
      line_mask   = ((OFF_W+1)'(1) << line_lg) - (OFF_W+1)'(1);
      total_raw   = {1'b0, item.request_bytes} + (OFF_W+1)'(barc_pkg::PREFIX_BYTES);
      total       = cfg.align_enable ? ((total_raw + line_mask) & ~line_mask) : total_raw;
      room        = {1'b0, arena_end} - {1'b0, alloc_offset_ff};
      fits        = !sealed && (total <= room);
   end

   // Address range check and release advance for a free.
   always_comb begin
      range_lo    = {1'b0, cfg.base_address} + (ADDR_W+1)'(barc_pkg::PREFIX_BYTES);
      range_hi    = {1'b0, cfg.base_address} + (ADDR_W+1)'(arena_end);
      in_range    = ({1'b0, item.release_address} >= range_lo) &&
                    ({1'b0, item.release_address} < range_hi);
      release_sum = {2'b00, release_offset_ff} + (OFF_W+2)'(barc_pkg::PREFIX_BYTES) +
                    {2'b00, stored_len};
      release_sat = (release_sum > (OFF_W+2)'(barc_pkg::OFFSET_MAX)) ?
                    OFF_W'(barc_pkg::OFFSET_MAX) : release_sum[OFF_W-1:0];
   end

   // Command decode and next pointer values.
   always_comb begin
      alloc_offset_in   = alloc_offset_ff;
      release_offset_in = release_offset_ff;
      seal_mark_in      = seal_mark_ff;
      status            = barc_pkg::ST_OK;
      granted           = '0;
      store_wr.en       = 1'b0;
      store_wr.addr     = alloc_offset_ff[barc_pkg::SLOT_W-1:0];
      store_wr.data     = total[OFF_W-1:0] - OFF_W'(barc_pkg::PREFIX_BYTES);

      unique case (item.command)
         barc_pkg::CMD_ALLOC: begin
            if (fits) begin
               store_wr.en     = item_valid;
               granted         = cfg.base_address + ADDR_W'(alloc_offset_ff) +
                                 ADDR_W'(barc_pkg::PREFIX_BYTES);
               alloc_offset_in = alloc_offset_ff + total[OFF_W-1:0];
            end else begin
               status = barc_pkg::ST_NO_SPACE;
            end
         end
         barc_pkg::CMD_FREE: begin
            if (in_range) begin
               release_offset_in = release_sat;
            end else begin
               status = barc_pkg::ST_OUT_OF_RANGE;
            end
         end
         barc_pkg::CMD_SEAL: begin
            if (!sealed) begin
               seal_mark_in    = alloc_offset_ff;
               alloc_offset_in = arena_end + OFF_W'(1);
            end
         end
         barc_pkg::CMD_REUSE: begin
            if (drained_now) begin
               alloc_offset_in   = '0;
               release_offset_in = '0;
               seal_mark_in      = '0;
            end else begin
               status = barc_pkg::ST_NOT_DRAINED;
            end
         end
         default: begin
         end
      endcase

      drained_next = (alloc_offset_in > arena_end) && (release_offset_in >= seal_mark_in);
      if ((item.command == barc_pkg::CMD_SEAL) && !drained_next) begin
         status = barc_pkg::ST_NOT_DRAINED;
      end
   end

   // Result word, taken after the update.
   always_comb begin
      rsp_in.valid           = item_valid;
      rsp_in.status          = status;
      rsp_in.granted_address = granted;
      rsp_in.free_bytes      = (alloc_offset_in < arena_end) ?
                               (arena_end - alloc_offset_in) : '0;
      rsp_in.released_bytes  = release_offset_in;
      rsp_in.drained         = drained_next;
   end

   // Pointer state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_offset_ff   <= '0;
         release_offset_ff <= '0;
         seal_mark_ff      <= '0;
         rsp_ff.valid      <= 1'b0;
      end else begin
         if (item_valid) begin
            alloc_offset_ff   <= alloc_offset_in;
            release_offset_ff <= release_offset_in;
            seal_mark_ff      <= seal_mark_in;
         end
         rsp_ff.valid <= rsp_in.valid;
      end
      rsp_ff.status          <= rsp_in.status;
      rsp_ff.granted_address <= rsp_in.granted_address;
      rsp_ff.free_bytes      <= rsp_in.free_bytes;
      rsp_ff.released_bytes  <= rsp_in.released_bytes;
      rsp_ff.drained         <= rsp_in.drained;
   end

   assign rsp = rsp_ff;

endmodule

[src/bump_allocator_with_release_count.sv]
// Top level of the bump allocator with release count.
// One command word is taken per cycle whenever busy is low (busy is high only
// while reset is applied). Its single result word is driven on the rsp_ ports
// from the clock edge after the accepting edge, for one cycle, marked by
// rsp_valid, and is taken at the edge that ends that cycle.
// The receiver cannot stall, so results must be captured when they are shown.
// The input register takes the command while the length store is read (a
// 4096-entry RAM with registered read); the execute stage updates the arena
// pointers and writes the store, with a bypass so that a free right after an
// alloc to the same block sees the new length. The length of a block that was
// never allocated is undefined.
module bump_allocator_with_release_count (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [2:0]                      req_command,
   input  logic [barc_pkg::OFF_W-1:0]      req_request_bytes,
   input  logic [barc_pkg::ADDR_W-1:0]     req_release_address,
   output logic                            rsp_valid,
   output logic [1:0]                      rsp_status,
   output logic [barc_pkg::ADDR_W-1:0]     rsp_granted_address,
   output logic [barc_pkg::OFF_W-1:0]      rsp_free_bytes,
   output logic [barc_pkg::OFF_W-1:0]      rsp_released_bytes,
   output logic                            rsp_drained,
   input  logic                            csr_write_enable,
   input  logic [barc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [barc_pkg::ADDR_W-1:0]     csr_data
);

   localparam int OFF_W  = barc_pkg::OFF_W;
   localparam int SLOT_W = barc_pkg::SLOT_W;
   localparam int ADDR_W = barc_pkg::ADDR_W;

   barc_pkg::cfg_type      cfg_ff;
   barc_pkg::item_type     item_ff;
   logic                   item_valid_ff;
   logic                   accept;
   logic [ADDR_W-1:0]      slot_full;
   logic [SLOT_W-1:0]      rd_addr;
   logic [OFF_W-1:0]       rd_data;
   logic                   fwd_hit_ff;
   logic [OFF_W-1:0]       fwd_data_ff;
   logic [OFF_W-1:0]       stored_len;
   barc_pkg::store_wr_type store_wr;
   barc_pkg::rsp_type      rsp;

   assign busy   = reset;
   assign accept = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_address <= '0;
         cfg_ff.buffer_size  <= OFF_W'(barc_pkg::BUFFER_BYTES);
         cfg_ff.align_enable <= 1'b0;
         cfg_ff.line_log2    <= 4'd6;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            barc_pkg::CSR_BASE_ADDRESS: cfg_ff.base_address <= csr_data;
            barc_pkg::CSR_BUFFER_SIZE:  cfg_ff.buffer_size  <= csr_data[OFF_W-1:0];
            barc_pkg::CSR_ALIGN_ENABLE: cfg_ff.align_enable <= csr_data[0];
            barc_pkg::CSR_LINE_LOG2:    cfg_ff.line_log2    <= csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= accept;
      end
      item_ff.command         <= req_command;
      item_ff.request_bytes   <= req_request_bytes;
      item_ff.release_address <= req_release_address;
   end

   // Length store slot of a free, read as the word is accepted.
   assign slot_full = req_release_address - cfg_ff.base_address -
                      ADDR_W'(barc_pkg::PREFIX_BYTES);
   assign rd_addr   = slot_full[SLOT_W-1:0];

   barc_ram #(
      .WIDTH (OFF_W),
      .DEPTH (barc_pkg::BUFFER_BYTES)
   ) u_length_store (
      .clock   (clock),
      .wr_en   (store_wr.en),
      .wr_addr (store_wr.addr),
      .wr_data (store_wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Bypass of a length written in the same cycle as the read.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else begin
         fwd_hit_ff <= store_wr.en && (store_wr.addr == rd_addr);
      end
      fwd_data_ff <= store_wr.data;
   end

   assign stored_len = fwd_hit_ff ? fwd_data_ff : rd_data;

   barc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .stored_len (stored_len),
      .store_wr   (store_wr),
      .rsp        (rsp)
   );

   assign rsp_valid           = rsp.valid;
   assign rsp_status          = rsp.status;
   assign rsp_granted_address = rsp.granted_address;
   assign rsp_free_bytes      = rsp.free_bytes;
   assign rsp_released_bytes  = rsp.released_bytes;
   assign rsp_drained         = rsp.drained;

   // Every accepted word is followed by a result from the result register.
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> ##1 rsp_valid)
      else $error("accepted word produced no result");

   // A failed or non-alloc command never grants an address.
   a_grant_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != barc_pkg::ST_OK)) |-> (rsp_granted_address == '0))
      else $error("address granted with non-ok status");

   // A drained arena is sealed, so it has no free bytes.
   a_drained_no_space: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_drained) |-> (rsp_free_bytes == '0))
      else $error("drained arena reports free bytes");

   // The length store is written only by a word in the execute stage.
   a_write_needs_item: assert property (@(posedge clock) disable iff (reset)
      store_wr.en |=> rsp_valid)
      else $error("length store written without a result");

endmodule

[test/testbench.sv]
// Self-checking testbench of the bump allocator with release count.
`timescale 1ns / 1ps

module testbench;

   localparam int ADDR_W    = barc_pkg::ADDR_W;
   localparam int OFF_W     = barc_pkg::OFF_W;
   localparam int CSR_IDX_W = barc_pkg::CSR_IDX_W;

   // One result word as the allocator reports it.
   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] granted_address;
      logic [OFF_W-1:0]  free_bytes;
      logic [OFF_W-1:0]  released_bytes;
      logic              drained;
   } arena_result_type;

   // Mirror of the arena: its registers, pointers, length store and the results still due.
   class arena_mirror_type;
      logic [ADDR_W-1:0] base_address;
      int                buffer_size;
      bit                align_on;
      int                line_log2;
      int                alloc_offset;
      int                release_offset;
      int                seal_mark;
      logic [OFF_W-1:0]  block_length [barc_pkg::BUFFER_BYTES];
      bit                written [barc_pkg::BUFFER_BYTES];
      int                stored_slots[$];
      int                live_slots[$];
      arena_result_type  due_results[$];
      int                fault_count;

      function new();
         base_address   = '0;
         buffer_size    = barc_pkg::BUFFER_BYTES;
         align_on       = 1'b0;
         line_log2      = 6;
         alloc_offset   = 0;
         release_offset = 0;
         seal_mark      = 0;
         fault_count    = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function int arena_end();
         return (buffer_size < barc_pkg::BUFFER_BYTES) ? buffer_size : barc_pkg::BUFFER_BYTES;
      endfunction

      function bit is_drained();
         return (alloc_offset > arena_end()) && (release_offset >= seal_mark);
      endfunction

      // True when a free of this address would read the length store.
      function bit in_range(logic [ADDR_W-1:0] address);
         logic [63:0] lo;
         logic [63:0] hi;
         lo = {32'd0, base_address} + barc_pkg::PREFIX_BYTES;
         hi = {32'd0, base_address} + arena_end();
         return ({32'd0, address} >= lo) && ({32'd0, address} < hi);
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [ADDR_W-1:0] value);
         case (index)
            barc_pkg::CSR_BASE_ADDRESS: base_address = value;
            barc_pkg::CSR_BUFFER_SIZE:  buffer_size  = int'(value[OFF_W-1:0]);
            barc_pkg::CSR_ALIGN_ENABLE: align_on     = value[0];
            barc_pkg::CSR_LINE_LOG2:    line_log2    = int'(value[3:0]);
            default: ;
         endcase
      endfunction

      // Apply one accepted command word and queue the result it must produce.
      function void take_command(logic [2:0] command, logic [OFF_W-1:0] request_bytes,
                                 logic [ADDR_W-1:0] release_address);
         int               last;
         int               total;
         int               lg;
         int               line;
         int               slot;
         int               next;
         arena_result_type r;
         last = arena_end();
         r = '0;
         case (command)
            barc_pkg::CMD_ALLOC: begin
               total = int'(request_bytes) + barc_pkg::PREFIX_BYTES;
               if (align_on) begin
                  lg = (line_log2 > barc_pkg::LINE_LOG2_MAX) ?
                       barc_pkg::LINE_LOG2_MAX : line_log2;
                  line = 1 << lg;
                  total = (total + line - 1) & ~(line - 1);
               end
               if (alloc_offset <= last && total <= last - alloc_offset) begin
                  // A successful alloc always starts below the store depth.
                  block_length[alloc_offset] = OFF_W'(total - barc_pkg::PREFIX_BYTES);
                  if (!written[alloc_offset]) begin
                     written[alloc_offset] = 1'b1;
                     stored_slots.push_back(alloc_offset);
                  end
                  live_slots.push_back(alloc_offset);
                  r.granted_address = base_address + ADDR_W'(alloc_offset)
                                      + ADDR_W'(barc_pkg::PREFIX_BYTES);
                  alloc_offset += total;
               end else begin
                  r.status = barc_pkg::ST_NO_SPACE;
               end
            end
            barc_pkg::CMD_FREE: begin
               if (!in_range(release_address)) begin
                  r.status = barc_pkg::ST_OUT_OF_RANGE;
               end else begin
                  slot = int'(release_address - base_address
                              - ADDR_W'(barc_pkg::PREFIX_BYTES));
                  next = release_offset + barc_pkg::PREFIX_BYTES + int'(block_length[slot]);
                  release_offset = (next > barc_pkg::OFFSET_MAX) ? barc_pkg::OFFSET_MAX : next;
               end
            end
            barc_pkg::CMD_SEAL: begin
               // A repeated seal keeps the first mark.
               if (alloc_offset <= last) begin
                  seal_mark = alloc_offset;
                  alloc_offset = last + 1;
               end
               if (!is_drained()) r.status = barc_pkg::ST_NOT_DRAINED;
            end
            barc_pkg::CMD_REUSE: begin
               if (is_drained()) begin
                  release_offset = 0;
                  alloc_offset   = 0;
                  seal_mark      = 0;
                  live_slots.delete();
               end else begin
                  r.status = barc_pkg::ST_NOT_DRAINED;
               end
            end
            default: ;
         endcase
         r.free_bytes     = (alloc_offset < last) ? OFF_W'(last - alloc_offset) : '0;
         r.released_bytes = OFF_W'(release_offset);
         r.drained        = is_drained();
         due_results.push_back(r);
      endfunction

      function void compare_field(string field, logic [ADDR_W-1:0] want,
                                  logic [ADDR_W-1:0] seen);
         if (seen !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, seen);
            fault_count++;
         end
      endfunction

      // Check one result word against the oldest expectation.
      function void match_result(arena_result_type seen);
         arena_result_type want;
         if (due_results.size() == 0) begin
            $display("%0t ns: result word with nothing expected, status %0d address %0h",
                     $time, seen.status, seen.granted_address);
            fault_count++;
            return;
         end
         want = due_results.pop_front();
         compare_field("status", ADDR_W'(want.status), ADDR_W'(seen.status));
         compare_field("granted_address", want.granted_address, seen.granted_address);
         compare_field("free_bytes", ADDR_W'(want.free_bytes), ADDR_W'(seen.free_bytes));
         compare_field("released_bytes", ADDR_W'(want.released_bytes),
                       ADDR_W'(seen.released_bytes));
         compare_field("drained", ADDR_W'(want.drained), ADDR_W'(seen.drained));
      endfunction
   endclass

   // Steps of one well-formed arena round.
   typedef enum {ROUND_ALLOC, ROUND_FREE, ROUND_SEAL, ROUND_REUSE} round_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [2:0]            req_command = '0;
   logic [OFF_W-1:0]      req_request_bytes = '0;
   logic [ADDR_W-1:0]     req_release_address = '0;
   logic                  rsp_valid;
   logic [1:0]            rsp_status;
   logic [ADDR_W-1:0]     rsp_granted_address;
   logic [OFF_W-1:0]      rsp_free_bytes;
   logic [OFF_W-1:0]      rsp_released_bytes;
   logic                  rsp_drained;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [ADDR_W-1:0]     csr_data = '0;

   arena_mirror_type      mirror;
   round_step_type        round_step;
   int                    allocs_left;

   bump_allocator_with_release_count dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_request_bytes   (req_request_bytes),
      .req_release_address (req_release_address),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_granted_address (rsp_granted_address),
      .rsp_free_bytes      (rsp_free_bytes),
      .rsp_released_bytes  (rsp_released_bytes),
      .rsp_drained         (rsp_drained),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   // Free-running clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Every result word is taken at the edge that ends its cycle.
   always @(posedge clock) begin
      arena_result_type seen;
      if (rsp_valid === 1'b1) begin
         seen.status          = rsp_status;
         seen.granted_address = rsp_granted_address;
         seen.free_bytes      = rsp_free_bytes;
         seen.released_bytes  = rsp_released_bytes;
         seen.drained         = rsp_drained;
         mirror.match_result(seen);
      end
   end

   // Hard stop in case the allocator hangs.
   initial begin
      #400000;
      $display("FAIL bump_allocator_with_release_count");
      $finish;
   end

   // Offer one command word after a random gap and note it once it is taken.
   task automatic send_word(logic [2:0] command, logic [OFF_W-1:0] request_bytes,
                            logic [ADDR_W-1:0] release_address, int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start               <= 1'b1;
      req_command         <= command;
      req_request_bytes   <= request_bytes;
      req_release_address <= release_address;
      @(posedge clock);
      while (busy) @(posedge clock);
      mirror.take_command(command, request_bytes, release_address);
   endtask

   // Hold the sender off until every result is in, then let the pipeline empty.
   task automatic settle();
      start <= 1'b0;
      while (mirror.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers; unused upper data bits carry random junk.
   task automatic write_registers(logic [ADDR_W-1:0] base, int size, bit align, int lg);
      logic [CSR_IDX_W-1:0] index [4];
      logic [ADDR_W-1:0]    value [4];
      index[0] = barc_pkg::CSR_BASE_ADDRESS;
      index[1] = barc_pkg::CSR_BUFFER_SIZE;
      index[2] = barc_pkg::CSR_ALIGN_ENABLE;
      index[3] = barc_pkg::CSR_LINE_LOG2;
      value[0] = base;
      value[1] = ($urandom & ~32'h1FFF) | ADDR_W'(size);
      value[2] = ($urandom & ~32'h1) | ADDR_W'(align);
      value[3] = ($urandom & ~32'hF) | ADDR_W'(lg);
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= index[i];
         csr_data         <= value[i];
         @(posedge clock);
         mirror.write_register(index[i], value[i]);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Address of a block that was written once and lies in the arena now.
   function automatic bit stored_block_address(output logic [ADDR_W-1:0] address);
      int slot;
      address = mirror.base_address;
      if (mirror.stored_slots.size() == 0) return 1'b0;
      repeat (8) begin
         slot = mirror.stored_slots[$urandom_range(0, mirror.stored_slots.size() - 1)];
         address = mirror.base_address + ADDR_W'(barc_pkg::PREFIX_BYTES) + ADDR_W'(slot);
         if (mirror.in_range(address)) return 1'b1;
      end
      return 1'b0;
   endfunction

   // Free address for noise words; never one that would read an unwritten length.
   function automatic logic [ADDR_W-1:0] noise_address();
      logic [ADDR_W-1:0] address;
      int                slot;
      case ($urandom_range(0, 3))
         0: address = $urandom;
         1: void'(stored_block_address(address));
         2: address = mirror.base_address + ADDR_W'(barc_pkg::PREFIX_BYTES - 1);
         default: address = mirror.base_address + ADDR_W'(mirror.arena_end());
      endcase
      if (mirror.in_range(address)) begin
         slot = int'(address - mirror.base_address - ADDR_W'(barc_pkg::PREFIX_BYTES));
         if (!mirror.written[slot]) address = mirror.base_address;
      end
      return address;
   endfunction

   // Next random word: mostly well-formed rounds of alloc, free, seal and reuse.
   task automatic pick_command(output logic [2:0] command, output logic [OFF_W-1:0] bytes,
                               output logic [ADDR_W-1:0] address);
      int k;
      command = barc_pkg::CMD_QUERY;
      bytes   = OFF_W'($urandom);
      address = $urandom;
      if ($urandom_range(99) < 15) begin
         command = 3'($urandom_range(0, 7));
         if (command == barc_pkg::CMD_FREE) address = noise_address();
         return;
      end
      if (round_step == ROUND_FREE && mirror.live_slots.size() == 0) round_step = ROUND_SEAL;
      case (round_step)
         ROUND_ALLOC: begin
            command = barc_pkg::CMD_ALLOC;
            if ($urandom_range(99) < 10) bytes = OFF_W'($urandom_range(0, mirror.arena_end()));
            else bytes = OFF_W'($urandom_range(0, 64));
            allocs_left--;
            if (allocs_left <= 0) round_step = ROUND_FREE;
         end
         ROUND_FREE: begin
            k = $urandom_range(0, mirror.live_slots.size() - 1);
            command = barc_pkg::CMD_FREE;
            address = mirror.base_address + ADDR_W'(barc_pkg::PREFIX_BYTES)
                      + ADDR_W'(mirror.live_slots[k]);
            mirror.live_slots.delete(k);
         end
         ROUND_SEAL: begin
            command = barc_pkg::CMD_SEAL;
            round_step = ROUND_REUSE;
         end
         default: begin
            // Reseal if a stray reuse reopened the arena; top up releases if short.
            if (mirror.alloc_offset <= mirror.arena_end()) begin
               command = barc_pkg::CMD_SEAL;
            end else if (!mirror.is_drained() && stored_block_address(address)) begin
               command = barc_pkg::CMD_FREE;
            end else begin
               command = barc_pkg::CMD_REUSE;
               round_step = ROUND_ALLOC;
               allocs_left = $urandom_range(1, 8);
            end
         end
      endcase
   endtask

   // Main sequence: reset, directed words, then random phases of varied settings.
   initial begin
      logic [2:0]        command;
      logic [OFF_W-1:0]  bytes;
      logic [ADDR_W-1:0] address;
      logic [ADDR_W-1:0] b;
      int                idle_pct [4];
      mirror = new();
      round_step = ROUND_ALLOC;
      allocs_left = 4;
      idle_pct[0] = 0;
      idle_pct[1] = 57;
      idle_pct[2] = 0;
      idle_pct[3] = 25;
      b = 32'h0000_1000;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_registers(b, barc_pkg::BUFFER_BYTES, 1'b0, 6);

      // Directed words: size extremes, a full arena, address bounds, seal and reuse.
      send_word(barc_pkg::CMD_QUERY, '0, '0, 0);
      send_word(barc_pkg::CMD_ALLOC, '0, '0, 0);
      send_word(barc_pkg::CMD_FREE, '0, b + 32'd8, 0);
      send_word(barc_pkg::CMD_ALLOC, OFF_W'(barc_pkg::BUFFER_BYTES), '0, 0);
      send_word(barc_pkg::CMD_ALLOC, '1, '0, 0);
      send_word(barc_pkg::CMD_ALLOC, OFF_W'(4080), '0, 0);
      send_word(barc_pkg::CMD_ALLOC, '0, '0, 0);
      send_word(barc_pkg::CMD_FREE, '0, b + 32'd16, 0);
      send_word(barc_pkg::CMD_FREE, '0, b + 32'd7, 0);
      send_word(barc_pkg::CMD_FREE, '0, b + 32'd4096, 0);
      send_word(barc_pkg::CMD_FREE, '0, '1, 0);
      send_word(barc_pkg::CMD_FREE, '0, '0, 0);
      // Reuse before seal is refused; a second seal keeps the mark.
      send_word(barc_pkg::CMD_REUSE, '0, '0, 0);
      send_word(barc_pkg::CMD_SEAL, '0, '0, 0);
      send_word(barc_pkg::CMD_SEAL, '0, '0, 0);
      send_word(barc_pkg::CMD_ALLOC, '0, '0, 0);
      send_word(barc_pkg::CMD_REUSE, '0, '0, 0);
      // Freeing one big block again and again saturates the released offset.
      repeat (3) send_word(barc_pkg::CMD_FREE, '0, b + 32'd16, 0);
      send_word(barc_pkg::CMD_SEAL, '0, '0, 0);
      send_word(barc_pkg::CMD_REUSE, '0, '0, 0);
      // Spare command codes act as a query.
      for (int k = 1; k <= 3; k++)
         send_word(3'(barc_pkg::CMD_QUERY) + 3'(k), OFF_W'($urandom), $urandom, 0);
      send_word(barc_pkg::CMD_ALLOC,
                OFF_W'(barc_pkg::BUFFER_BYTES - barc_pkg::PREFIX_BYTES), '0, 0);
      send_word(barc_pkg::CMD_SEAL, '0, '0, 0);
      send_word(barc_pkg::CMD_REUSE, '0, '0, 0);
      settle();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_registers('0, barc_pkg::BUFFER_BYTES, 1'b0, 6);
            1: write_registers(32'hFFFF_F800, barc_pkg::BUFFER_BYTES, 1'b1,
                               barc_pkg::LINE_LOG2_MAX);
            2: write_registers($urandom, 8191, 1'b1, 0);
            3: write_registers(32'h0000_1000, 0, 1'b0, 15);
            4: write_registers($urandom, 200, 1'b1, 3);
            5: write_registers($urandom, 4095, 1'b1, 13);
            6: write_registers('1, 64, 1'b0, 4);
            default: write_registers($urandom, barc_pkg::BUFFER_BYTES, 1'b1, 6);
         endcase
         for (int n = 0; n < 200; n++) begin
            pick_command(command, bytes, address);
            send_word(command, bytes, address, idle_pct[phase % 4]);
         end
         settle();
      end

      if (mirror.fault_count == 0 && mirror.due_results.size() == 0) begin
         $display("PASS bump_allocator_with_release_count");
      end else begin
         $display("FAIL bump_allocator_with_release_count");
      end
      $finish;
   end

endmodule

[files.f]
src/barc_pkg.sv
src/barc_ram.sv
src/barc_core.sv
src/bump_allocator_with_release_count.sv
test/testbench.sv
